### rtl/sitbcd_pkg.sv
// ----------------------------------------------------------------------------
// sitbcd_pkg
// Shared constants and types for the signed integer to BCD digit-write block.
// ----------------------------------------------------------------------------
package sitbcd_pkg;

  localparam int MAG_W           = 32;
  localparam int COUNT_W         = 8;
  localparam int CODE_W          = 4;
  localparam int REG_W           = 4;
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = BCD_DIGITS * CODE_W;
  localparam int DIGIT_POSITIONS = 8;
  localparam int BITS_PER_STEP   = 4;
  localparam int CONV_STEPS      = MAG_W / BITS_PER_STEP;
  localparam int STEP_W          = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CODE_W-1:0]  MINUS_RESET = CODE_W'(10);
  localparam logic [COUNT_W-1:0] POS_LIMIT   = COUNT_W'(DIGIT_POSITIONS);
  localparam logic [COUNT_W-1:0] DIGIT_LIMIT = COUNT_W'(BCD_DIGITS);
  localparam logic [REG_W-1:0]   MINUS_REG   = REG_W'(1);

  typedef logic [BCD_DIGITS-1:0][CODE_W-1:0] bcd_t;

  // One converted item waiting between the converter and the write sequencer.
  typedef struct packed {
    bcd_t                 digits;
    logic [COUNT_W-1:0]   count;
    logic                 negative;
  } item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIGIT,
    B_MINUS
  } back_state_t;

endpackage

### rtl/sitbcd_front.sv
// ----------------------------------------------------------------------------
// sitbcd_front
// Accepts a value, takes its magnitude and converts it to ten BCD digits by
// shift-and-add-3, four bits per cycle, then hands the item to the queue.
// ----------------------------------------------------------------------------
module sitbcd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [sitbcd_pkg::MAG_W-1:0]   signed_value,
  input  logic [sitbcd_pkg::COUNT_W-1:0] digit_count,
  input  logic                           q_full,
  output logic                           q_push,
  output sitbcd_pkg::item_t              q_item
);
  import sitbcd_pkg::*;

  front_state_t       state, state_next;
  logic [STEP_W-1:0]  step;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   mag_next;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_next;
  logic [COUNT_W-1:0] count;
  logic               negative;
  logic               accept;
  logic               last_step;

  assign accept    = start && (state == F_IDLE);
  assign last_step = (step == STEP_W'(CONV_STEPS - 1));

  // Four dependent shift-and-correct steps over all BCD digits.
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] m;
    b = bcd;
    m = mag;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (b[d*CODE_W +: CODE_W] >= CODE_W'(5)) begin
          b[d*CODE_W +: CODE_W] = b[d*CODE_W +: CODE_W] + CODE_W'(3);
        end
      end
      b = {b[BCD_W-2:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
    end
    bcd_next = b;
    mag_next = m;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (start) state_next = F_CONV;
      end
      F_CONV: begin
        if (last_step) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != F_IDLE);
    q_push = (state == F_PUSH) && !q_full;
    q_item = '{digits: bcd_t'(bcd), count: count, negative: negative};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
      end else if (state == F_CONV) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= signed_value[MAG_W-1];
      // Two's complement negate also gives the right magnitude for the most
      // negative value when read as unsigned.
      mag      <= signed_value[MAG_W-1] ? (~signed_value + MAG_W'(1)) : signed_value;
      bcd      <= '0;
      count    <= digit_count;
    end else if (state == F_CONV) begin
      mag <= mag_next;
      bcd <= bcd_next;
    end
  end

  property p_push_not_full;
    @(posedge clk) disable iff (rst) q_push |-> !q_full;
  endproperty
  a_push_not_full: assert property (p_push_not_full)
    else $error("front pushed into a full queue");

  property p_conv_length;
    @(posedge clk) disable iff (rst) (state == F_CONV) && !last_step |=> (state == F_CONV);
  endproperty
  a_conv_length: assert property (p_conv_length)
    else $error("conversion left before its final step");

  property p_accept_starts_conv;
    @(posedge clk) disable iff (rst) accept |=> (state == F_CONV) && (step == '0);
  endproperty
  a_accept_starts_conv: assert property (p_accept_starts_conv)
    else $error("accepted item did not start conversion");

endmodule

### rtl/sitbcd_queue.sv
// ----------------------------------------------------------------------------
// sitbcd_queue
// Two-entry queue of converted items between the converter and the write
// sequencer.
// ----------------------------------------------------------------------------
module sitbcd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sitbcd_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output sitbcd_pkg::item_t head
);
  import sitbcd_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  property p_no_underflow;
    @(posedge clk) disable iff (rst) pop |-> !empty;
  endproperty
  a_no_underflow: assert property (p_no_underflow)
    else $error("queue popped while empty");

  property p_no_overflow;
    @(posedge clk) disable iff (rst) push |-> !full;
  endproperty
  a_no_overflow: assert property (p_no_overflow)
    else $error("queue pushed while full");

  property p_fill_bound;
    @(posedge clk) disable iff (rst) fill <= QCNT_W'(QUEUE_DEPTH);
  endproperty
  a_fill_bound: assert property (p_fill_bound)
    else $error("queue fill count out of range");

endmodule

### rtl/sitbcd_back.sv
// ----------------------------------------------------------------------------
// sitbcd_back
// Write sequencer: takes one converted item from the queue and issues its
// digit-register writes one per cycle, then the minus write if negative.
// ----------------------------------------------------------------------------
module sitbcd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  sitbcd_pkg::item_t             q_head,
  output logic                          q_pop,
  input  logic [sitbcd_pkg::CODE_W-1:0] minus_code,
  output logic                          strobe,
  output logic [sitbcd_pkg::REG_W-1:0]  digit_register,
  output logic [sitbcd_pkg::CODE_W-1:0] digit_code,
  output logic                          last_write
);
  import sitbcd_pkg::*;

  back_state_t        state, state_next;
  item_t              cur;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] first_idx;
  logic [COUNT_W-1:0] diff;
  logic               final_digit;

  // Digits that would land beyond the last display position are skipped.
  assign first_idx   = (q_head.count > POS_LIMIT) ? (q_head.count - POS_LIMIT) : '0;
  assign final_digit = (idx == cur.count - COUNT_W'(1));
  assign diff        = cur.count - idx;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_head.count != '0)  state_next = B_DIGIT;
          else if (q_head.negative) state_next = B_MINUS;
          else                      state_next = B_IDLE;
        end
      end
      B_DIGIT: begin
        if (final_digit) state_next = cur.negative ? B_MINUS : B_IDLE;
      end
      B_MINUS: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop          = (state == B_IDLE) && !q_empty;
    strobe         = 1'b0;
    digit_register = diff[REG_W-1:0];
    digit_code     = '0;
    last_write     = 1'b0;
    case (state)
      B_DIGIT: begin
        strobe     = 1'b1;
        last_write = final_digit && !cur.negative;
        // Digits past the tenth are leading zeros.
        if (idx < DIGIT_LIMIT) digit_code = cur.digits[idx[3:0]];
      end
      B_MINUS: begin
        strobe         = 1'b1;
        digit_register = MINUS_REG;
        digit_code     = minus_code;
        last_write     = 1'b1;
      end
      default: begin
        strobe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
      idx <= first_idx;
    end else if (state == B_DIGIT) begin
      idx <= idx + COUNT_W'(1);
    end
  end

  property p_register_range;
    @(posedge clk) disable iff (rst)
      strobe |-> (digit_register >= REG_W'(1)) && (digit_register <= REG_W'(DIGIT_POSITIONS));
  endproperty
  a_register_range: assert property (p_register_range)
    else $error("write to a register outside the display");

  property p_minus_write;
    @(posedge clk) disable iff (rst)
      (state == B_MINUS) |-> strobe && last_write && (digit_register == MINUS_REG);
  endproperty
  a_minus_write: assert property (p_minus_write)
    else $error("minus write malformed");

  property p_gap_after_last;
    @(posedge clk) disable iff (rst) (strobe && last_write) |=> !strobe;
  endproperty
  a_gap_after_last: assert property (p_gap_after_last)
    else $error("write issued right after the final beat of an item");

endmodule

### rtl/signed_int_to_bcd_digit_writes.sv
// ----------------------------------------------------------------------------
// signed_int_to_bcd_digit_writes
// Turns a signed 32-bit value and a digit count into display digit-register
// writes, least significant digit first, with an optional final minus write.
// ----------------------------------------------------------------------------
// A new start is taken only while the converter is idle: after the accept cycle
// it converts four bits per cycle, then pushes the item, waiting while the queue
// is full. The sequencer pops an item, then issues one write per cycle.
// Reset clears both control machines and the queue; the stored minus code returns to 10.
// The receiver cannot stall: each write is a one-cycle strobe.
module signed_int_to_bcd_digit_writes (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [sitbcd_pkg::MAG_W-1:0]   signed_value,
  input  logic [sitbcd_pkg::COUNT_W-1:0] digit_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sitbcd_pkg::CODE_W-1:0]  minus_code,
  output logic                           strobe,
  output logic [sitbcd_pkg::REG_W-1:0]   digit_register,
  output logic [sitbcd_pkg::CODE_W-1:0]  digit_code,
  output logic                           last_write
);
  import sitbcd_pkg::*;

  logic [CODE_W-1:0] minus_reg;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  item_t             q_in;
  item_t             q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      minus_reg <= MINUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      minus_reg <= minus_code;
    end
  end

  sitbcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .signed_value (signed_value),
    .digit_count  (digit_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  sitbcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sitbcd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .minus_code     (minus_reg),
    .strobe         (strobe),
    .digit_register (digit_register),
    .digit_code     (digit_code),
    .last_write     (last_write)
  );

endmodule
